/* sv/json_string_decoder_macros.svh */
// Assertion macros shared by the checker of the JSON string decoder.
// Standalone header; expects signals clk and arst_n in the including scope.
`ifndef JSON_STRING_DECODER_MACROS_SVH
`define JSON_STRING_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/jsd_pkg.sv */
// Shared types and constants of the JSON string decoder.
// No dependencies; imported by the decode stage, the result buffer and the checker.
package jsd_pkg;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	localparam int LIMIT_W     = 13;
	localparam int LIMIT_RESET = 64;
	localparam int MAX_RESULTS = 5;

	// Results caused by one input byte: up to four UTF-8 bytes and an optional
	// completion or error marker after them.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      n_data;
		logic            tail;
		status_t         tail_status;
	} jsd_group_t;

endpackage

/* sv/jsd_decode.sv */
// Decode stage: string state machine, escape and UTF-8 checks, re-encoding.
// Depends on jsd_pkg. Produces the result group of the byte being transferred.
module jsd_decode import jsd_pkg::*; #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [7:0]         in_byte,
	input  logic               in_eoi,
	input  logic [LIMIT_W-1:0] limit,
	output jsd_group_t         grp
);

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int SW = (CW + 1 > LIMIT_W) ? CW + 1 : LIMIT_W;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX_HIGH,
		PH_WANT_BS,
		PH_WANT_U,
		PH_HEX_LOW,
		PH_CONT
	} phase_t;

	phase_t        phase_q, ph_d;
	logic [20:0]   cp_q, cp_d;
	logic [9:0]    high_q, hi_d;
	logic [2:0]    pend_q, pend_d;
	logic [1:0]    minc_q, minc_d;
	logic [CW-1:0] ocnt_q, ocnt_d;

	logic          err, done, emit_req, fits;
	logic [20:0]   emit_cp, min_cp, cont_cp;
	logic [15:0]   hex_cp;
	logic [3:0]    hex_val;
	logic          hex_ok;
	logic [2:0]    pend_m1, enc_cnt;
	logic [3:0][7:0] enc;
	logic [SW-1:0] sum;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
		             (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = 4'(in_byte[3:0] + 4'd9);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign hex_cp  = {cp_q[11:0], hex_val};
	assign cont_cp = {cp_q[14:0], in_byte[5:0]};
	assign pend_m1 = pend_q - 3'd1;

	always_comb begin
		case (minc_q)
			2'd0:    min_cp = 21'h80;
			2'd1:    min_cp = 21'h800;
			default: min_cp = 21'h10000;
		endcase
	end

	// Next state and the code point to emit, if any.
	always_comb begin
		ph_d     = phase_q;
		cp_d     = cp_q;
		hi_d     = high_q;
		pend_d   = pend_q;
		minc_d   = minc_q;
		err      = 1'b0;
		done     = 1'b0;
		emit_req = 1'b0;
		emit_cp  = '0;
		case (phase_q)
			PH_IDLE: begin
				if (in_byte == CH_QUOTE) ph_d = PH_BODY;
				else err = 1'b1;
			end
			PH_BODY: begin
				if (in_byte == CH_QUOTE) begin
					done = 1'b1;
				end else if (in_byte < 8'h20) begin
					err = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					ph_d = PH_ESC;
				end else if (in_byte < 8'h80) begin
					emit_req = 1'b1;
					emit_cp  = {13'd0, in_byte};
				end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
					cp_d   = {16'd0, in_byte[4:0]};
					pend_d = 3'd1;
					minc_d = 2'd0;
					ph_d   = PH_CONT;
				end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
					cp_d   = {17'd0, in_byte[3:0]};
					pend_d = 3'd2;
					minc_d = 2'd1;
					ph_d   = PH_CONT;
				end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
					cp_d   = {18'd0, in_byte[2:0]};
					pend_d = 3'd3;
					minc_d = 2'd2;
					ph_d   = PH_CONT;
				end else begin
					err = 1'b1;
				end
			end
			PH_ESC: begin
				emit_req = 1'b1;
				case (in_byte)
					CH_QUOTE, CH_BSLASH, CH_SLASH: emit_cp = {13'd0, in_byte};
					CH_B: emit_cp = 21'd8;
					CH_F: emit_cp = 21'd12;
					CH_N: emit_cp = 21'd10;
					CH_R: emit_cp = 21'd13;
					CH_T: emit_cp = 21'd9;
					CH_U: begin
						emit_req = 1'b0;
						cp_d     = '0;
						pend_d   = 3'd4;
						ph_d     = PH_HEX_HIGH;
					end
					default: begin
						emit_req = 1'b0;
						err      = 1'b1;
					end
				endcase
			end
			PH_HEX_HIGH, PH_HEX_LOW: begin
				if (!hex_ok) begin
					err = 1'b1;
				end else begin
					cp_d   = {5'd0, hex_cp};
					pend_d = pend_m1;
					if (pend_m1 == 3'd0) begin
						if (phase_q == PH_HEX_HIGH) begin
							if (hex_cp >= 16'hd800 && hex_cp <= 16'hdbff) begin
								hi_d = hex_cp[9:0];
								ph_d = PH_WANT_BS;
							end else if (hex_cp >= 16'hdc00 && hex_cp <= 16'hdfff) begin
								err = 1'b1;
							end else begin
								emit_req = 1'b1;
								emit_cp  = {5'd0, hex_cp};
							end
						end else if (hex_cp < 16'hdc00 || hex_cp > 16'hdfff) begin
							err = 1'b1;
						end else begin
							emit_req = 1'b1;
							emit_cp  = 21'h10000 + {1'b0, high_q, hex_cp[9:0]};
						end
					end
				end
			end
			PH_WANT_BS: begin
				if (in_byte == CH_BSLASH) ph_d = PH_WANT_U;
				else err = 1'b1;
			end
			PH_WANT_U: begin
				if (in_byte == CH_U) begin
					cp_d   = '0;
					pend_d = 3'd4;
					ph_d   = PH_HEX_LOW;
				end else begin
					err = 1'b1;
				end
			end
			PH_CONT: begin
				if (in_byte[7:6] != 2'b10) begin
					err = 1'b1;
				end else begin
					cp_d   = cont_cp;
					pend_d = pend_m1;
					if (pend_m1 == 3'd0) begin
						if (cont_cp < min_cp || cont_cp > 21'h10ffff ||
						    (cont_cp >= 21'hd800 && cont_cp <= 21'hdfff)) begin
							err = 1'b1;
						end else begin
							emit_req = 1'b1;
							emit_cp  = cont_cp;
						end
					end
				end
			end
			default: err = 1'b1;
		endcase
	end

	// UTF-8 encoding of the code point to emit.
	always_comb begin
		enc = '0;
		if (emit_cp < 21'h80) begin
			enc_cnt = 3'd1;
			enc[0]  = emit_cp[7:0];
		end else if (emit_cp < 21'h800) begin
			enc_cnt = 3'd2;
			enc[0]  = {3'b110, emit_cp[10:6]};
			enc[1]  = {2'b10, emit_cp[5:0]};
		end else if (emit_cp < 21'h10000) begin
			enc_cnt = 3'd3;
			enc[0]  = {4'b1110, emit_cp[15:12]};
			enc[1]  = {2'b10, emit_cp[11:6]};
			enc[2]  = {2'b10, emit_cp[5:0]};
		end else begin
			enc_cnt = 3'd4;
			enc[0]  = {5'b11110, emit_cp[20:18]};
			enc[1]  = {2'b10, emit_cp[17:12]};
			enc[2]  = {2'b10, emit_cp[11:6]};
			enc[3]  = {2'b10, emit_cp[5:0]};
		end
	end

	assign sum  = SW'(ocnt_q) + SW'(enc_cnt);
	assign fits = (sum <= SW'(limit)) && (sum <= SW'(MAX_LENGTH));

	// Results of this byte and the final phase.
	phase_t ph_f;
	logic   emit_ok;

	always_comb begin
		emit_ok = emit_req && (emit_cp != 21'd0) && fits;
		ph_f    = ph_d;
		ocnt_d  = ocnt_q;
		grp     = '0;
		if (phase_q == PH_IDLE) ocnt_d = '0;
		if (emit_ok) begin
			grp.data   = enc;
			grp.n_data = enc_cnt;
			ocnt_d     = sum[CW-1:0];
			ph_f       = PH_BODY;
		end
		if (err || (emit_req && !emit_ok)) begin
			grp.data        = '0;
			grp.n_data      = 3'd0;
			grp.tail        = 1'b1;
			grp.tail_status = ST_ERROR;
			ph_f            = PH_IDLE;
		end else if (done) begin
			grp.tail        = 1'b1;
			grp.tail_status = ST_DONE;
			ph_f            = PH_IDLE;
		end else if (in_eoi && ph_f != PH_IDLE) begin
			grp.tail        = 1'b1;
			grp.tail_status = ST_ERROR;
			ph_f            = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cp_q    <= '0;
			high_q  <= '0;
			pend_q  <= '0;
			minc_q  <= '0;
			ocnt_q  <= '0;
		end else if (in_fire) begin
			phase_q <= ph_f;
			cp_q    <= cp_d;
			high_q  <= hi_d;
			pend_q  <= pend_d;
			minc_q  <= minc_d;
			ocnt_q  <= ocnt_d;
		end
	end

endmodule

/* sv/jsd_emit.sv */
// Result buffer: holds the result group of one byte and sends it one result
// per transfer. Depends on jsd_pkg.
module jsd_emit import jsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  jsd_group_t grp,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output status_t    out_status,
	output logic       out_last
);

	jsd_group_t grp_s1;
	logic [2:0] cnt_q, idx_q;
	logic [2:0] total;
	logic       is_data, out_fire;

	assign total     = grp.n_data + {2'd0, grp.tail};
	assign out_valid = (cnt_q != 3'd0);
	assign is_data   = (idx_q < grp_s1.n_data);
	assign out_last  = out_valid && (idx_q == cnt_q - 3'd1);
	assign out_byte  = is_data ? grp_s1.data[idx_q[1:0]] : 8'd0;
	assign out_status = is_data ? ST_DATA : grp_s1.tail_status;
	assign out_fire  = out_valid && out_ready;
	// A new group may enter while the last result of the old one leaves.
	assign room      = !out_valid || (out_fire && out_last);

	always_ff @(posedge clk) begin
		if (load) grp_s1 <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= total;
			idx_q <= '0;
		end else if (out_fire) begin
			if (out_last) cnt_q <= '0;
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

/* sv/json_string_decoder.sv */
// Streaming decoder for one quoted JSON string: one raw byte per input transfer,
// escapes and UTF-8 checked and re-encoded, one result per output transfer.
// Depends on jsd_pkg, jsd_decode and jsd_emit.
//
// A byte is decoded in the cycle it is transferred and its results (up to four
// UTF-8 bytes, then a completion or error marker) land in a result buffer.
// Results leave one per cycle, while m_axis_tready is high, through the single
// output channel; the input is ready again in the cycle the last of a byte's
// results is transferred, giving one byte per cycle for plain ASCII text when
// the output does not stall. Bytes that cause no result (escape prefix, partial
// sequences) leave the buffer empty. length_limit may be written at any time
// the block is idle and takes effect on the next byte.
module json_string_decoder import jsd_pkg::*; #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               length_limit_we,
	input  logic [LIMIT_W-1:0] length_limit_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] in_byte
	input  logic               s_axis_tlast,  // end_of_input
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]         m_axis_tuser,  // [1:0] status
	output logic               m_axis_tlast   // last_of_run
);

	logic [LIMIT_W-1:0] limit_q;
	logic               in_fire;
	jsd_group_t         grp;
	status_t            out_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_W'(LIMIT_RESET);
		else if (length_limit_we) limit_q <= length_limit_wdata;
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	jsd_decode #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.in_byte (s_axis_tdata),
		.in_eoi  (s_axis_tlast),
		.limit   (limit_q),
		.grp     (grp)
	);

	jsd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_fire),
		.grp        (grp),
		.room       (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tuser = out_status;

endmodule

/* sv/jsd_checker.sv */
// Port-level checker for the JSON string decoder, bound to the top level.
// Depends on jsd_pkg and json_string_decoder_macros.svh.
`include "json_string_decoder_macros.svh"

module jsd_checker import jsd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// A stalled result holds until transferred.
	`JSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

	`JSD_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == ST_DATA || m_axis_tuser == ST_DONE || m_axis_tuser == ST_ERROR, "undefined status code")

	// Completion and error markers close the results of a byte.
	`JSD_ASSERT_NOW(a_marker_last, m_axis_tvalid && m_axis_tuser != ST_DATA, m_axis_tlast, "marker not last of run")

	`JSD_ASSERT_NOW(a_marker_zero, m_axis_tvalid && m_axis_tuser != ST_DATA, m_axis_tdata == 8'd0, "marker carries data")

endmodule

bind json_string_decoder jsd_checker u_jsd_checker (.*);
